[sv/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// Direct-mapped cache hit tracker package
// Shared widths, reset values, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Address split. The line count is a top-level parameter.
  localparam int ADDR_W        = 32;
  localparam int OFFSET_BITS   = 2;
  localparam int NUM_LINES_DEF = 8;

  // Result field widths.
  localparam int LINE_INDEX_W = 3;
  localparam int LINE_TAG_W   = 27;
  localparam int COUNT_W      = 32;
  localparam int RATIO_W      = 17;
  localparam int AMAT_W       = 24;

  // Fixed-point scaling of the ratio and of the access time.
  localparam int RATIO_FRAC = 16;
  localparam int AMAT_FRAC  = 8;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << RATIO_FRAC);

  // Cycle weights and the weighted cycle sum.
  localparam int CYC_W  = 16;
  localparam int PROD_W = COUNT_W + CYC_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = CYC_W;
  localparam logic [CFG_INDEX_W-1:0] REG_HIT_CYCLES  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MISS_CYCLES = CFG_INDEX_W'(1);

  // Hit costs the cache time, a miss the cache time plus the memory time.
  localparam logic [CYC_W-1:0] CACHE_CYCLES    = CYC_W'(5);
  localparam logic [CYC_W-1:0] MEMORY_CYCLES   = CYC_W'(100);
  localparam logic [CYC_W-1:0] HIT_CYCLES_RST  = CACHE_CYCLES;
  localparam logic [CYC_W-1:0] MISS_CYCLES_RST = CACHE_CYCLES + MEMORY_CYCLES;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MULT,
    ST_AMAT,
    ST_OUTPUT
  } dmc_state_t;

endpackage

[sv/dmc_if.sv]
// ----------------------------------------------------------------------------
// Direct-mapped cache hit tracker channels
// Valid/ready channels for addresses, results and register writes.
// ----------------------------------------------------------------------------

// Address channel.
interface dmc_in_if;
  import dmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// Result channel.
interface dmc_out_if;
  import dmc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [LINE_INDEX_W-1:0] line_index;
  logic [LINE_TAG_W-1:0]   line_tag;
  logic [COUNT_W-1:0]      access_count;
  logic [COUNT_W-1:0]      hit_count;
  logic [COUNT_W-1:0]      miss_count;
  logic [RATIO_W-1:0]      hit_ratio_q16;
  logic [RATIO_W-1:0]      miss_ratio_q16;
  logic [AMAT_W-1:0]       amat_q8;

  modport source (
    output valid, output hit, output line_index, output line_tag,
    output access_count, output hit_count, output miss_count,
    output hit_ratio_q16, output miss_ratio_q16, output amat_q8,
    input  ready
  );
  modport sink (
    input  valid, input hit, input line_index, input line_tag,
    input  access_count, input hit_count, input miss_count,
    input  hit_ratio_q16, input miss_ratio_q16, input amat_q8,
    output ready
  );
endinterface

// Register write channel.
interface dmc_cfg_if;
  import dmc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/dmc_tag_store.sv]
// ----------------------------------------------------------------------------
// Tag store
// One valid bit and one stored tag per line; registered tag read, miss fill.
// ----------------------------------------------------------------------------
module dmc_tag_store #(
  parameter int NUM_LINES = dmc_pkg::NUM_LINES_DEF,
  parameter int TAG_W     = dmc_pkg::ADDR_W - dmc_pkg::OFFSET_BITS
                            - $clog2(dmc_pkg::NUM_LINES_DEF)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_LINES)-1:0] rd_idx,
  input  logic                         lk_en,
  input  logic [$clog2(NUM_LINES)-1:0] lk_idx,
  input  logic [TAG_W-1:0]             lk_tag,
  output logic                         lk_hit
);

  logic [NUM_LINES-1:0] valid_r;
  logic [TAG_W-1:0]     tag_mem [NUM_LINES];
  logic [TAG_W-1:0]     rd_tag_r;
  logic                 fill;

  // A line hits when it holds data and its stored tag matches.
  assign lk_hit = valid_r[lk_idx] && (rd_tag_r == lk_tag);
  assign fill   = lk_en && !lk_hit;

  // Tag read, issued when the address is taken.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag_r <= tag_mem[rd_idx];
    end
  end

  // Tag write on a miss.
  always_ff @(posedge clk) begin
    if (fill) begin
      tag_mem[lk_idx] <= lk_tag;
    end
  end

  // Valid bits, cleared by reset and set by a fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (fill) begin
      valid_r[lk_idx] <= 1'b1;
    end
  end

endmodule

[sv/dmc_serial_mac.sv]
// ----------------------------------------------------------------------------
// Bit-serial weighted sum
// Forms a*ka + b*kb, one bit of the weights per cycle, most significant first.
// ----------------------------------------------------------------------------
module dmc_serial_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dmc_pkg::COUNT_W-1:0] a,
  input  logic [dmc_pkg::COUNT_W-1:0] b,
  input  logic [dmc_pkg::CYC_W-1:0]   ka,
  input  logic [dmc_pkg::CYC_W-1:0]   kb,
  output logic                        busy,
  output logic [dmc_pkg::PROD_W-1:0]  result
);
  import dmc_pkg::*;

  localparam int CNT_W = $clog2(CYC_W + 1);

  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [COUNT_W-1:0] a_r, b_r;
  logic [CYC_W-1:0]   ka_r, kb_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;

  // Double the running sum and add each operand whose weight bit is set.
  always_comb begin
    acc_nxt = {acc_r[PROD_W-2:0], 1'b0}
              + (ka_r[CYC_W-1] ? PROD_W'(a_r) : '0)
              + (kb_r[CYC_W-1] ? PROD_W'(b_r) : '0);
  end

  // Operand and weight shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      ka_r  <= ka;
      kb_r  <= kb;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      ka_r  <= ka_r << 1;
      kb_r  <= kb_r << 1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(CYC_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy   = busy_r;
  assign result = acc_r;

endmodule

[sv/dmc_serial_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, for quotients known to fit.
// ----------------------------------------------------------------------------
module dmc_serial_div #(
  parameter int NUM_W  = dmc_pkg::COUNT_W + dmc_pkg::RATIO_FRAC,
  parameter int QUOT_W = dmc_pkg::RATIO_W,
  parameter int DEN_W  = dmc_pkg::COUNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-1:0] lo_r;
  logic [QUOT_W-1:0] quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // Bring down the next numerator bit and try one subtraction.
  assign trial = {rem_r, lo_r[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // Remainder and quotient shift registers. The upper part of the numerator
  // is already below the divisor, so only the low bits need steps.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= DEN_W'(num >> QUOT_W);
      lo_r   <= num[QUOT_W-1:0];
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r   <= lo_r << 1;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QUOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

[sv/direct_mapped_cache_hit_tracker_top.sv]
// ----------------------------------------------------------------------------
// Direct-mapped cache hit tracker
// Tag lookup with fill on miss, saturating counters, hit ratio and AMAT.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   in_chan   in         valid/ready    address
//   out_chan  out        valid/ready    hit, line, tag, counts, ratios, amat_q8
//   cfg_chan  in         valid/ready    register index and write data
//
// A transaction passes in order through the lookup, the bit-serial weighted
// cycle sum (whose end starts the division), the bit-serial division that
// yields amat_q8, the load of the result register, and idle, where the next
// address is taken.
// The tag read happens at the acceptance edge. The hit ratio divides in
// parallel with the cycle sum.
// Reset is synchronous: it clears the valid bits, counters and control state and resets the cycle weights.
// A stalled result waits in the output register while the next address is
// taken; the block then holds its finished result until that register frees.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_tracker_top #(
  parameter int NUM_LINES = dmc_pkg::NUM_LINES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dmc_in_if.sink     in_chan,
  dmc_out_if.source  out_chan,
  dmc_cfg_if.sink    cfg_chan
);
  import dmc_pkg::*;

  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int TAG_W  = ADDR_W - OFFSET_BITS - IDX_W;
  localparam int RNUM_W = COUNT_W + RATIO_FRAC;
  localparam int ANUM_W = PROD_W + AMAT_FRAC;

  dmc_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  addr_r;
  logic [IDX_W-1:0]   in_idx, cur_idx;
  logic [TAG_W-1:0]   cur_tag;
  logic               hit_r;
  logic               lk_hit;
  logic [CYC_W-1:0]   hit_cycles_r, miss_cycles_r;
  logic [COUNT_W-1:0] acc_r, acc_nxt;
  logic [COUNT_W-1:0] hits_r, hits_nxt;
  logic [COUNT_W-1:0] misses_r, misses_nxt;

  logic in_take, lookup_en, calc_start, amat_start, out_load;
  logic mac_busy, ratio_busy, amat_busy;
  logic [PROD_W-1:0]  mac_result;
  logic [RATIO_W-1:0] ratio_quot;
  logic [AMAT_W-1:0]  amat_quot;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [LINE_INDEX_W-1:0] out_index_r;
  logic [LINE_TAG_W-1:0]   out_tag_r;
  logic [COUNT_W-1:0]      out_acc_r, out_hits_r, out_misses_r;
  logic [RATIO_W-1:0]      out_hr_r, out_mr_r;
  logic [AMAT_W-1:0]       out_amat_r;

  // Address split into offset, line index and tag.
  assign in_idx  = in_chan.address[OFFSET_BITS +: IDX_W];
  assign cur_idx = addr_r[OFFSET_BITS +: IDX_W];
  assign cur_tag = addr_r[ADDR_W-1 -: TAG_W];

  assign in_take = in_chan.valid && in_chan.ready;

  // Controller: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_take) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_MULT;
      ST_MULT:   if (!mac_busy) state_nxt = ST_AMAT;
      ST_AMAT:   if (!amat_busy && !ratio_busy) state_nxt = ST_OUTPUT;
      ST_OUTPUT: if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Controller: outputs.
  always_comb begin
    in_chan.ready = 1'b0;
    lookup_en     = 1'b0;
    calc_start    = 1'b0;
    amat_start    = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_LOOKUP: begin
        lookup_en  = 1'b1;
        calc_start = 1'b1;
      end
      ST_MULT:   amat_start = !mac_busy;
      ST_AMAT:   ;
      ST_OUTPUT: out_load = !out_valid_r || out_chan.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Address and hit flag of the transaction in progress.
  always_ff @(posedge clk) begin
    if (in_take) begin
      addr_r <= in_chan.address;
    end
    if (lookup_en) begin
      hit_r <= lk_hit;
    end
  end

  // Cycle weights written through the register port.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cycles_r  <= HIT_CYCLES_RST;
      miss_cycles_r <= MISS_CYCLES_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_HIT_CYCLES:  hit_cycles_r  <= cfg_chan.data;
        REG_MISS_CYCLES: miss_cycles_r <= cfg_chan.data;
        default:         ;
      endcase
    end
  end

  // Counters stop together once the access count is full.
  always_comb begin
    acc_nxt    = acc_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (lookup_en && (acc_r != COUNT_MAX)) begin
      acc_nxt = acc_r + COUNT_W'(1);
      if (lk_hit) begin
        hits_nxt = hits_r + COUNT_W'(1);
      end else begin
        misses_nxt = misses_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else begin
      acc_r    <= acc_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  // Tag store.
  dmc_tag_store #(
    .NUM_LINES (NUM_LINES),
    .TAG_W     (TAG_W)
  ) u_tag_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_take),
    .rd_idx (in_idx),
    .lk_en  (lookup_en),
    .lk_idx (cur_idx),
    .lk_tag (cur_tag),
    .lk_hit (lk_hit)
  );

  // Weighted cycle sum over hits and misses.
  dmc_serial_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (calc_start),
    .a      (hits_nxt),
    .b      (misses_nxt),
    .ka     (hit_cycles_r),
    .kb     (miss_cycles_r),
    .busy   (mac_busy),
    .result (mac_result)
  );

  // Hit ratio in Q1.16.
  dmc_serial_div #(
    .NUM_W  (RNUM_W),
    .QUOT_W (RATIO_W),
    .DEN_W  (COUNT_W)
  ) u_ratio_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_start),
    .num   ({hits_nxt, {RATIO_FRAC{1'b0}}}),
    .den   (acc_nxt),
    .busy  (ratio_busy),
    .quot  (ratio_quot)
  );

  // Average memory access time in Q.8.
  dmc_serial_div #(
    .NUM_W  (ANUM_W),
    .QUOT_W (AMAT_W),
    .DEN_W  (COUNT_W)
  ) u_amat_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (amat_start),
    .num   ({mac_result, {AMAT_FRAC{1'b0}}}),
    .den   (acc_r),
    .busy  (amat_busy),
    .quot  (amat_quot)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r    <= hit_r;
      out_index_r  <= LINE_INDEX_W'(cur_idx);
      out_tag_r    <= LINE_TAG_W'(cur_tag);
      out_acc_r    <= acc_r;
      out_hits_r   <= hits_r;
      out_misses_r <= misses_r;
      out_hr_r     <= ratio_quot;
      out_mr_r     <= RATIO_ONE - ratio_quot;
      out_amat_r   <= amat_quot;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.hit            = out_hit_r;
  assign out_chan.line_index     = out_index_r;
  assign out_chan.line_tag       = out_tag_r;
  assign out_chan.access_count   = out_acc_r;
  assign out_chan.hit_count      = out_hits_r;
  assign out_chan.miss_count     = out_misses_r;
  assign out_chan.hit_ratio_q16  = out_hr_r;
  assign out_chan.miss_ratio_q16 = out_mr_r;
  assign out_chan.amat_q8        = out_amat_r;

`ifndef NO_ASSERTIONS
  // Every access is counted as exactly one hit or one miss.
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, acc_r} == ({1'b0, hits_r} + {1'b0, misses_r}))
    else $error("access count differs from hits plus misses");

  // The counters move only in the lookup cycle.
  a_count_when: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(acc_r) |-> $past(state_r) == ST_LOOKUP)
    else $error("access count changed outside the lookup cycle");

  // The hit ratio is ready before the access time division ends.
  a_ratio_first: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(amat_busy) |-> !ratio_busy)
    else $error("ratio division still running at the end of the AMAT division");

  // A new result appears only from the result-load state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUTPUT)
    else $error("result raised outside the result-load state");
`endif

endmodule
